// File: hdl/mtep_pkg.sv
`default_nettype none

package mtep_pkg;

  localparam int CHANNEL_COUNT = 16;
  localparam int CHANNEL_BITS  = $clog2(CHANNEL_COUNT);

  localparam logic [7:0] META_STATUS  = 8'hFF;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
  localparam logic [7:0] META_END     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
  localparam logic [3:0] HI_NOTE_ON     = 4'h9;
  localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
  localparam logic [3:0] HI_CONTROL     = 4'hB;
  localparam logic [3:0] HI_PROGRAM     = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND  = 4'hE;
  localparam logic [3:0] HI_SYSTEM      = 4'hF;

  localparam logic [3:0] SYS_SONG_POS = 4'h2;
  localparam logic [3:0] SYS_SONG_SEL = 4'h3;

  typedef enum logic [2:0] {
    KIND_NOTE    = 3'd0,
    KIND_TEMPO   = 3'd1,
    KIND_PROGRAM = 3'd2,
    KIND_END     = 3'd3,
    KIND_CORRUPT = 3'd4
  } kind_t;

  typedef enum logic [10:0] {
    PH_DELTA      = 11'b000_0000_0001,
    PH_STATUS     = 11'b000_0000_0010,
    PH_NOTE_PITCH = 11'b000_0000_0100,
    PH_NOTE_VEL   = 11'b000_0000_1000,
    PH_PROG       = 11'b000_0001_0000,
    PH_SKIP       = 11'b000_0010_0000,
    PH_SYSEX_LEN  = 11'b000_0100_0000,
    PH_META_TYPE  = 11'b000_1000_0000,
    PH_META_LEN   = 11'b001_0000_0000,
    PH_TEMPO      = 11'b010_0000_0000,
    PH_HALT       = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  pitch;
    logic [7:0]  velocity;
    logic [23:0] tempo_us;
    logic [7:0]  program_res;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/midi_track_event_parser.sv
// Parser for the body of one track chunk of a standard MIDI file, one byte per
// transfer on the input channel; in_track_start marks the first byte of a track.
// Each accepted byte updates the parser state in the same cycle, so the block
// takes one byte in every clock cycle while in_stall is low. A byte that
// completes an event (note on, tempo, first program change of a channel, end
// of track or corrupt data) gives one result on the output channel, registered
// in the result register; other bytes give none. The result register is
// followed by one skid entry, so a stalled receiver does not hold up the input
// at once: when a result is held in the output register by out_stall and a
// second one is produced, the second goes to the skid entry and in_stall rises
// until the receiver takes a result. Stalled results are held unchanged. The
// output pair sustains one result per cycle while out_stall is low.
// Synchronous reset clears the parser state, tick and program flags, and
// discards any buffered results.
`default_nettype none

module midi_track_event_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_track_start,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_event_kind,
  output logic [31:0] out_tick,
  output logic [3:0]  out_channel,
  output logic [7:0]  out_pitch,
  output logic [7:0]  out_velocity,
  output logic [23:0] out_tempo_us,
  output logic [7:0]  out_program_res
);

  logic              fire;
  logic              res_valid;
  logic              skid_full;
  mtep_pkg::result_t res;
  mtep_pkg::result_t out_res;

  assign in_stall = skid_full;
  assign fire     = in_valid & ~skid_full;

  mtep_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_byte),
    .track_start (in_track_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  mtep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign out_event_kind  = out_res.kind;
  assign out_tick        = out_res.tick;
  assign out_channel     = out_res.channel;
  assign out_pitch       = out_res.pitch;
  assign out_velocity    = out_res.velocity;
  assign out_tempo_us    = out_res.tempo_us;
  assign out_program_res = out_res.program_res;

endmodule

`default_nettype wire

// File: hdl/mtep_core.sv
`default_nettype none

module mtep_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  wire  [7:0]           data_byte,
  input  wire                  track_start,
  output logic                 res_valid,
  output mtep_pkg::result_t    res
);

  mtep_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [7:0]  rs_r, rs_nxt, cur_rs;
  logic [31:0] tick_r, tick_nxt, cur_tick;
  logic [27:0] varlen_r, varlen_nxt, cur_varlen;
  logic [27:0] skip_r, skip_nxt, cur_skip;
  logic [7:0]  first_r, first_nxt, cur_first;
  logic [7:0]  meta_r, meta_nxt, cur_meta;
  logic [23:0] tacc_r, tacc_nxt, cur_tacc;
  logic [1:0]  tbytes_r, tbytes_nxt, cur_tbytes;
  logic [mtep_pkg::CHANNEL_COUNT-1:0] seen_r, seen_nxt, cur_seen;

  logic [27:0] acc_new;
  logic        vl_last;
  logic [27:0] skip_dec;
  logic [7:0]  msg_rs;
  logic        is_data;
  logic [1:0]  msg_n;
  logic [mtep_pkg::CHANNEL_BITS-1:0] prog_ch;
  logic [23:0] tacc_shift;

  assign cur_phase  = track_start ? mtep_pkg::PH_DELTA : phase_r;
  assign cur_rs     = track_start ? 8'd0 : rs_r;
  assign cur_tick   = track_start ? 32'd0 : tick_r;
  assign cur_varlen = track_start ? 28'd0 : varlen_r;
  assign cur_skip   = track_start ? 28'd0 : skip_r;
  assign cur_first  = track_start ? 8'd0 : first_r;
  assign cur_meta   = track_start ? 8'd0 : meta_r;
  assign cur_tacc   = track_start ? 24'd0 : tacc_r;
  assign cur_tbytes = track_start ? 2'd0 : tbytes_r;
  assign cur_seen   = track_start ? '0 : seen_r;

  assign acc_new    = {cur_varlen[20:0], data_byte[6:0]};
  assign vl_last    = ~data_byte[7];
  assign skip_dec   = cur_skip - 28'd1;
  assign is_data    = ~data_byte[7];
  assign msg_rs     = is_data ? cur_rs : data_byte;
  assign prog_ch    = cur_rs[mtep_pkg::CHANNEL_BITS-1:0];
  assign tacc_shift = {cur_tacc[15:0], data_byte};

  always_comb begin
    unique case (msg_rs[7:4])
      mtep_pkg::HI_CHAN_PRESS: msg_n = 2'd1;
      mtep_pkg::HI_SYSTEM: begin
        if (msg_rs[3:0] == mtep_pkg::SYS_SONG_POS) begin
          msg_n = 2'd2;
        end else if (msg_rs[3:0] == mtep_pkg::SYS_SONG_SEL) begin
          msg_n = 2'd1;
        end else begin
          msg_n = 2'd0;
        end
      end
      default: msg_n = 2'd2;
    endcase
  end

  always_comb begin
    phase_nxt  = cur_phase;
    rs_nxt     = cur_rs;
    tick_nxt   = cur_tick;
    varlen_nxt = cur_varlen;
    skip_nxt   = cur_skip;
    first_nxt  = cur_first;
    meta_nxt   = cur_meta;
    tacc_nxt   = cur_tacc;
    tbytes_nxt = cur_tbytes;
    seen_nxt   = cur_seen;
    res_valid  = 1'b0;
    res        = '0;
    res.tick   = cur_tick;

    unique case (cur_phase)
      mtep_pkg::PH_DELTA: begin
        if (vl_last) begin
          tick_nxt   = cur_tick + {4'd0, acc_new};
          varlen_nxt = '0;
          phase_nxt  = mtep_pkg::PH_STATUS;
        end else begin
          varlen_nxt = acc_new;
        end
      end
      mtep_pkg::PH_STATUS: begin
        if (data_byte == mtep_pkg::META_STATUS) begin
          rs_nxt    = '0;
          phase_nxt = mtep_pkg::PH_META_TYPE;
        end else if (data_byte == mtep_pkg::SYSEX_START ||
                     data_byte == mtep_pkg::SYSEX_ESCAPE) begin
          rs_nxt    = '0;
          phase_nxt = mtep_pkg::PH_SYSEX_LEN;
        end else begin
          if (!is_data) begin
            rs_nxt = data_byte;
          end
          unique case (msg_rs[7:4])
            mtep_pkg::HI_NOTE_ON: begin
              if (is_data) begin
                first_nxt = data_byte;
                phase_nxt = mtep_pkg::PH_NOTE_VEL;
              end else begin
                phase_nxt = mtep_pkg::PH_NOTE_PITCH;
              end
            end
            mtep_pkg::HI_PROGRAM: begin
              if (is_data) begin
                phase_nxt = mtep_pkg::PH_DELTA;
                if (!cur_seen[prog_ch]) begin
                  seen_nxt[prog_ch] = 1'b1;
                  res_valid         = 1'b1;
                  res.kind          = mtep_pkg::KIND_PROGRAM;
                  res.channel       = cur_rs[3:0];
                  res.program_res   = data_byte;
                end
              end else begin
                phase_nxt = mtep_pkg::PH_PROG;
              end
            end
            mtep_pkg::HI_NOTE_OFF, mtep_pkg::HI_POLY_PRESS, mtep_pkg::HI_CONTROL,
            mtep_pkg::HI_CHAN_PRESS, mtep_pkg::HI_PITCH_BEND,
            mtep_pkg::HI_SYSTEM: begin
              if (is_data) begin
                if (msg_n == 2'd0) begin
                  if (vl_last) begin
                    tick_nxt   = cur_tick + {4'd0, acc_new};
                    varlen_nxt = '0;
                    phase_nxt  = mtep_pkg::PH_STATUS;
                  end else begin
                    varlen_nxt = acc_new;
                    phase_nxt  = mtep_pkg::PH_DELTA;
                  end
                end else if (msg_n == 2'd1) begin
                  phase_nxt = mtep_pkg::PH_DELTA;
                end else begin
                  skip_nxt  = 28'd1;
                  phase_nxt = mtep_pkg::PH_SKIP;
                end
              end else if (msg_n == 2'd0) begin
                phase_nxt = mtep_pkg::PH_DELTA;
              end else begin
                skip_nxt  = {26'd0, msg_n};
                phase_nxt = mtep_pkg::PH_SKIP;
              end
            end
            default: begin
              phase_nxt = mtep_pkg::PH_HALT;
              res_valid = 1'b1;
              res.kind  = mtep_pkg::KIND_CORRUPT;
            end
          endcase
        end
      end
      mtep_pkg::PH_NOTE_PITCH: begin
        first_nxt = data_byte;
        phase_nxt = mtep_pkg::PH_NOTE_VEL;
      end
      mtep_pkg::PH_NOTE_VEL: begin
        phase_nxt    = mtep_pkg::PH_DELTA;
        res_valid    = 1'b1;
        res.kind     = mtep_pkg::KIND_NOTE;
        res.channel  = cur_rs[3:0];
        res.pitch    = cur_first;
        res.velocity = data_byte;
      end
      mtep_pkg::PH_PROG: begin
        phase_nxt = mtep_pkg::PH_DELTA;
        if (!cur_seen[prog_ch]) begin
          seen_nxt[prog_ch] = 1'b1;
          res_valid         = 1'b1;
          res.kind          = mtep_pkg::KIND_PROGRAM;
          res.channel       = cur_rs[3:0];
          res.program_res   = data_byte;
        end
      end
      mtep_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 28'd0) begin
          phase_nxt = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        if (vl_last) begin
          varlen_nxt = '0;
          if (acc_new == 28'd0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
          end else begin
            skip_nxt  = acc_new;
            phase_nxt = mtep_pkg::PH_SKIP;
          end
        end else begin
          varlen_nxt = acc_new;
        end
      end
      mtep_pkg::PH_META_TYPE: begin
        meta_nxt  = data_byte;
        phase_nxt = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        if (vl_last) begin
          varlen_nxt = '0;
          if (cur_meta == mtep_pkg::META_END) begin
            phase_nxt = mtep_pkg::PH_HALT;
            res_valid = 1'b1;
            res.kind  = mtep_pkg::KIND_END;
          end else if (cur_meta == mtep_pkg::META_TEMPO) begin
            tacc_nxt   = '0;
            tbytes_nxt = '0;
            if (acc_new == 28'd0) begin
              phase_nxt = mtep_pkg::PH_DELTA;
              res_valid = 1'b1;
              res.kind  = mtep_pkg::KIND_TEMPO;
            end else begin
              skip_nxt  = acc_new;
              phase_nxt = mtep_pkg::PH_TEMPO;
            end
          end else if (acc_new == 28'd0) begin
            phase_nxt = mtep_pkg::PH_DELTA;
          end else begin
            skip_nxt  = acc_new;
            phase_nxt = mtep_pkg::PH_SKIP;
          end
        end else begin
          varlen_nxt = acc_new;
        end
      end
      mtep_pkg::PH_TEMPO: begin
        if (cur_tbytes != 2'd3) begin
          tacc_nxt   = tacc_shift;
          tbytes_nxt = cur_tbytes + 2'd1;
        end
        skip_nxt = skip_dec;
        if (skip_dec == 28'd0) begin
          phase_nxt    = mtep_pkg::PH_DELTA;
          res_valid    = 1'b1;
          res.kind     = mtep_pkg::KIND_TEMPO;
          res.tempo_us = (cur_tbytes != 2'd3) ? tacc_shift : cur_tacc;
        end
      end
      mtep_pkg::PH_HALT: begin
      end
      default: begin
      end
    endcase

    if (!fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mtep_pkg::PH_DELTA;
      rs_r     <= '0;
      tick_r   <= '0;
      varlen_r <= '0;
      skip_r   <= '0;
      first_r  <= '0;
      meta_r   <= '0;
      tacc_r   <= '0;
      tbytes_r <= '0;
      seen_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      rs_r     <= rs_nxt;
      tick_r   <= tick_nxt;
      varlen_r <= varlen_nxt;
      skip_r   <= skip_nxt;
      first_r  <= first_nxt;
      meta_r   <= meta_nxt;
      tacc_r   <= tacc_nxt;
      tbytes_r <= tbytes_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mtep_out_buf.sv
`default_nettype none

module mtep_out_buf (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      res_valid,
  input  wire  mtep_pkg::result_t  res,
  input  wire                      out_stall,
  output logic                     out_valid,
  output mtep_pkg::result_t        out_res,
  output logic                     skid_full
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  mtep_pkg::result_t out_r, out_nxt;
  mtep_pkg::result_t skid_r, skid_nxt;
  logic              out_free;

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign skid_full = skid_valid_r;

endmodule

`default_nettype wire
